/* hdl/sstcp_pkg.sv */
// Shared constants and helpers for the serial set-time command parser.
package sstcp_pkg;

   localparam int LINE_MAX_DEFAULT = 24;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;

   localparam int DIGIT_W = 4;
   localparam int DIGITS = 6;
   localparam int SLOT_W = 3;
   localparam int VALUE_W = 7;

   localparam int CMD_LEN = 16;
   localparam int PREFIX_LEN = 8;
   localparam int COLON_POS_0 = 10;
   localparam int COLON_POS_1 = 13;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam logic [7:0] PREFIX_TEXT [0:PREFIX_LEN-1] = '{
      8'h53, 8'h45, 8'h54, 8'h54, 8'h49, 8'h4D, 8'h45, 8'h3D
   };

   localparam logic [VALUE_W-1:0] HOUR_MAX = 7'd23;
   localparam logic [VALUE_W-1:0] MIN_SEC_MAX = 7'd59;

   localparam logic [SLOT_W-1:0] SLOT_HOUR_TENS = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_HOUR_ONES = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_MIN_TENS = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_MIN_ONES = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_SEC_TENS = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_SEC_ONES = 3'd5;

   // tens * 10 + ones, as shift-and-add
   function automatic logic [VALUE_W-1:0] two_digit_value(
      input logic [DIGIT_W-1:0] tens,
      input logic [DIGIT_W-1:0] ones
   );
      logic [VALUE_W-1:0] acc;
      acc = {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
      return acc;
   endfunction

endpackage

/* hdl/serial_set_time_command_parser.sv */
// Serial set-time command parser: line assembly, pattern check and time verdict.
//
// Usage:
//   req_* carries received serial bytes, one per transfer (req_tdata[7:0]).
//   CR or LF ends a line. A nonempty line gives one transfer on rsp_*; an
//   empty line gives none. A non-terminator byte arriving on a full line
//   (LINE_MAX-1 bytes held) discards the line and is dropped.
//   rsp_tuser is 1 when the line was a valid SETTIME=HH:MM:SS command with
//   the time in range; rsp_tdata then holds binary and BCD time, else zeros.
//   A terminator passes through the input register, then the result register,
//   before its result shows on rsp_*.
//   Throughput: one byte per cycle while no held result stalls rsp_*; the
//   position check between the input and result registers is combinational.
//   Reset clears the line state and both valid flags; no pass is needed.
//   When rsp_tready is low with a result held, the input register fills and
//   req_tready drops; nothing is lost and the held result stays stable.
module serial_set_time_command_parser #(
   parameter int LINE_MAX = sstcp_pkg::LINE_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] rx_byte
   input  logic [sstcp_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [4:0] hour_bin, [10:5] minute_bin, [16:11] second_bin,
   // [22:17] hour_bcd, [29:23] minute_bcd, [36:30] second_bcd, [39:37] zero
   output logic [sstcp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] accepted
   output logic [sstcp_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   localparam int LenW = $clog2(LINE_MAX);
   localparam logic [LenW-1:0] LenLimit = LenW'(LINE_MAX - 1);
   localparam logic [LenW-1:0] CmdLen = LenW'(sstcp_pkg::CMD_LEN);

   logic                                   in_valid_ff, in_valid_in;
   logic [sstcp_pkg::REQ_DATA_W-1:0]       in_byte_ff, in_byte_in;
   logic [LenW-1:0]                        line_len_ff, line_len_in;
   logic                                   pattern_ok_ff, pattern_ok_in;
   logic [sstcp_pkg::DIGIT_W-1:0]          digit_ff [sstcp_pkg::DIGITS];
   logic [sstcp_pkg::DIGIT_W-1:0]          digit_in [sstcp_pkg::DIGITS];
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [sstcp_pkg::RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [sstcp_pkg::RSP_USER_W-1:0]       rsp_user_ff, rsp_user_in;

   logic                                   advance;
   logic                                   process;
   logic                                   is_term;
   logic                                   has_room;
   logic                                   byte_ok;
   logic                                   is_digit;
   logic                                   slot_hit;
   logic [sstcp_pkg::SLOT_W-1:0]           slot;
   logic [sstcp_pkg::VALUE_W-1:0]          hour_val, min_val, sec_val;
   logic                                   verdict;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign process = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   assign is_term = (in_byte_ff == sstcp_pkg::CHAR_CR) || (in_byte_ff == sstcp_pkg::CHAR_LF);
   assign has_room = line_len_ff < LenLimit;
   assign is_digit = (in_byte_ff >= sstcp_pkg::CHAR_ZERO) && (in_byte_ff <= sstcp_pkg::CHAR_NINE);

   // per-position pattern check
   always_comb begin
      if (line_len_ff < LenW'(sstcp_pkg::PREFIX_LEN)) begin
         byte_ok = in_byte_ff == sstcp_pkg::PREFIX_TEXT[line_len_ff[2:0]];
      end else if (line_len_ff inside {LenW'(sstcp_pkg::COLON_POS_0),
                                       LenW'(sstcp_pkg::COLON_POS_1)}) begin
         byte_ok = in_byte_ff == sstcp_pkg::CHAR_COLON;
      end else if (line_len_ff == CmdLen) begin
         byte_ok = in_byte_ff == sstcp_pkg::CHAR_NUL;
      end else if (line_len_ff > CmdLen) begin
         byte_ok = 1'b1;
      end else begin
         byte_ok = is_digit;
      end
   end

   always_comb begin
      slot_hit = 1'b1;
      case (line_len_ff)
         LenW'(8):  slot = sstcp_pkg::SLOT_HOUR_TENS;
         LenW'(9):  slot = sstcp_pkg::SLOT_HOUR_ONES;
         LenW'(11): slot = sstcp_pkg::SLOT_MIN_TENS;
         LenW'(12): slot = sstcp_pkg::SLOT_MIN_ONES;
         LenW'(14): slot = sstcp_pkg::SLOT_SEC_TENS;
         LenW'(15): slot = sstcp_pkg::SLOT_SEC_ONES;
         default: begin
            slot = sstcp_pkg::SLOT_HOUR_TENS;
            slot_hit = 1'b0;
         end
      endcase
   end

   assign hour_val = sstcp_pkg::two_digit_value(digit_ff[sstcp_pkg::SLOT_HOUR_TENS],
                                                digit_ff[sstcp_pkg::SLOT_HOUR_ONES]);
   assign min_val = sstcp_pkg::two_digit_value(digit_ff[sstcp_pkg::SLOT_MIN_TENS],
                                               digit_ff[sstcp_pkg::SLOT_MIN_ONES]);
   assign sec_val = sstcp_pkg::two_digit_value(digit_ff[sstcp_pkg::SLOT_SEC_TENS],
                                               digit_ff[sstcp_pkg::SLOT_SEC_ONES]);

   assign verdict = pattern_ok_ff && (line_len_ff >= CmdLen)
                    && (hour_val <= sstcp_pkg::HOUR_MAX)
                    && (min_val <= sstcp_pkg::MIN_SEC_MAX)
                    && (sec_val <= sstcp_pkg::MIN_SEC_MAX);

   always_comb begin
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      in_byte_in = (req_tvalid && req_tready) ? req_tdata : in_byte_ff;

      line_len_in = line_len_ff;
      pattern_ok_in = pattern_ok_ff;
      digit_in = digit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;

      if (process) begin
         if (is_term) begin
            line_len_in = '0;
            pattern_ok_in = 1'b1;
            if (line_len_ff != '0) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = verdict;
               if (verdict) begin
                  rsp_data_in = {
                     3'b000,
                     digit_ff[sstcp_pkg::SLOT_SEC_TENS][2:0],
                     digit_ff[sstcp_pkg::SLOT_SEC_ONES],
                     digit_ff[sstcp_pkg::SLOT_MIN_TENS][2:0],
                     digit_ff[sstcp_pkg::SLOT_MIN_ONES],
                     digit_ff[sstcp_pkg::SLOT_HOUR_TENS][1:0],
                     digit_ff[sstcp_pkg::SLOT_HOUR_ONES],
                     sec_val[5:0],
                     min_val[5:0],
                     hour_val[4:0]
                  };
               end else begin
                  rsp_data_in = '0;
               end
            end
         end else if (has_room) begin
            if (!byte_ok) begin
               pattern_ok_in = 1'b0;
            end else if (slot_hit) begin
               digit_in[slot] = in_byte_ff[3:0];
            end
            line_len_in = line_len_ff + LenW'(1);
         end else begin
            // full line: drop it along with this byte
            line_len_in = '0;
            pattern_ok_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         line_len_ff <= '0;
         pattern_ok_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < sstcp_pkg::DIGITS; i++) begin
            digit_ff[i] <= '0;
         end
      end else begin
         in_valid_ff <= in_valid_in;
         line_len_ff <= line_len_in;
         pattern_ok_ff <= pattern_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         digit_ff <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

/* bench/tb_serial_set_time_command_parser.sv */
// Self-checking testbench for the serial set-time command parser.
`timescale 1ns / 1ps

typedef struct packed {
   logic [2:0] pad;
   logic [6:0] second_bcd;
   logic [6:0] minute_bcd;
   logic [5:0] hour_bcd;
   logic [5:0] second_bin;
   logic [5:0] minute_bin;
   logic [4:0] hour_bin;
} time_word_type;

typedef struct packed {
   logic          accepted;
   time_word_type word;
} line_verdict_type;

class time_scoreboard;
   line_verdict_type verdicts_due[$];
   int unsigned      line_len;
   bit               pattern_ok;
   logic [3:0]       digits [sstcp_pkg::DIGITS];
   int               errors;
   int               n_accepted;
   int               n_rejected;

   function new();
      line_len = 0;
      pattern_ok = 1'b1;
      foreach (digits[i]) digits[i] = '0;
      errors = 0;
      n_accepted = 0;
      n_rejected = 0;
   endfunction

   function int pending();
      return verdicts_due.size();
   endfunction

   // advance the line model by one accepted byte
   function void note_rx_byte(logic [7:0] b, int line_max);
      line_verdict_type v;
      int               slot;
      bit               hit;
      int unsigned      len;
      int unsigned      hh;
      int unsigned      mm;
      int unsigned      ss;
      logic [7:0]       d;
      if (b == sstcp_pkg::CHAR_CR || b == sstcp_pkg::CHAR_LF) begin
         len = line_len;
         hit = pattern_ok && len >= sstcp_pkg::CMD_LEN;
         line_len = 0;
         pattern_ok = 1'b1;
         if (len == 0) return;
         v = '0;
         hh = digits[sstcp_pkg::SLOT_HOUR_TENS] * 10 + digits[sstcp_pkg::SLOT_HOUR_ONES];
         mm = digits[sstcp_pkg::SLOT_MIN_TENS] * 10 + digits[sstcp_pkg::SLOT_MIN_ONES];
         ss = digits[sstcp_pkg::SLOT_SEC_TENS] * 10 + digits[sstcp_pkg::SLOT_SEC_ONES];
         if (hit && hh <= sstcp_pkg::HOUR_MAX && mm <= sstcp_pkg::MIN_SEC_MAX
             && ss <= sstcp_pkg::MIN_SEC_MAX) begin
            v.accepted = 1'b1;
            v.word.hour_bin = hh[4:0];
            v.word.minute_bin = mm[5:0];
            v.word.second_bin = ss[5:0];
            v.word.hour_bcd = {digits[sstcp_pkg::SLOT_HOUR_TENS][1:0],
                               digits[sstcp_pkg::SLOT_HOUR_ONES]};
            v.word.minute_bcd = {digits[sstcp_pkg::SLOT_MIN_TENS][2:0],
                                 digits[sstcp_pkg::SLOT_MIN_ONES]};
            v.word.second_bcd = {digits[sstcp_pkg::SLOT_SEC_TENS][2:0],
                                 digits[sstcp_pkg::SLOT_SEC_ONES]};
            n_accepted++;
         end else begin
            n_rejected++;
         end
         verdicts_due.push_back(v);
      end else if (line_len < line_max - 1) begin
         slot = -1;
         case (line_len)
            sstcp_pkg::PREFIX_LEN:      slot = sstcp_pkg::SLOT_HOUR_TENS;
            sstcp_pkg::PREFIX_LEN + 1:  slot = sstcp_pkg::SLOT_HOUR_ONES;
            sstcp_pkg::COLON_POS_0 + 1: slot = sstcp_pkg::SLOT_MIN_TENS;
            sstcp_pkg::COLON_POS_0 + 2: slot = sstcp_pkg::SLOT_MIN_ONES;
            sstcp_pkg::COLON_POS_1 + 1: slot = sstcp_pkg::SLOT_SEC_TENS;
            sstcp_pkg::COLON_POS_1 + 2: slot = sstcp_pkg::SLOT_SEC_ONES;
            default:                    slot = -1;
         endcase
         if (line_len < sstcp_pkg::PREFIX_LEN) begin
            hit = (b == sstcp_pkg::PREFIX_TEXT[line_len]);
         end else if (line_len == sstcp_pkg::COLON_POS_0
                      || line_len == sstcp_pkg::COLON_POS_1) begin
            hit = (b == sstcp_pkg::CHAR_COLON);
         end else if (line_len == sstcp_pkg::CMD_LEN) begin
            hit = (b == sstcp_pkg::CHAR_NUL);
         end else if (line_len > sstcp_pkg::CMD_LEN) begin
            hit = 1'b1;
         end else begin
            hit = (b >= sstcp_pkg::CHAR_ZERO && b <= sstcp_pkg::CHAR_NINE);
         end
         if (!hit) begin
            pattern_ok = 1'b0;
         end else if (slot >= 0) begin
            d = b - sstcp_pkg::CHAR_ZERO;
            digits[slot] = d[3:0];
         end
         line_len++;
      end else begin
         // overflow: line dropped along with this byte
         line_len = 0;
         pattern_ok = 1'b1;
      end
   endfunction

   function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_verdict(logic accepted, logic [sstcp_pkg::RSP_DATA_W-1:0] data);
      line_verdict_type exp_v;
      time_word_type    act;
      act = data;
      if (verdicts_due.size() == 0) begin
         $display("%0t: unexpected result, expected none, got tuser %0h tdata %0h",
                  $time, accepted, data);
         errors++;
         return;
      end
      exp_v = verdicts_due.pop_front();
      cmp_field("accepted", exp_v.accepted, accepted);
      cmp_field("hour_bin", exp_v.word.hour_bin, act.hour_bin);
      cmp_field("minute_bin", exp_v.word.minute_bin, act.minute_bin);
      cmp_field("second_bin", exp_v.word.second_bin, act.second_bin);
      cmp_field("hour_bcd", exp_v.word.hour_bcd, act.hour_bcd);
      cmp_field("minute_bcd", exp_v.word.minute_bcd, act.minute_bcd);
      cmp_field("second_bcd", exp_v.word.second_bcd, act.second_bcd);
      cmp_field("pad", exp_v.word.pad, act.pad);
   endfunction
endclass

module tb_serial_set_time_command_parser;
   localparam int LINE_MAX = sstcp_pkg::LINE_MAX_DEFAULT;
   localparam int TOTAL_BYTES = 850;
   localparam int CYCLE_LIMIT = 200000;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_tvalid;
   logic                                  req_tready;
   logic [sstcp_pkg::REQ_DATA_W-1:0]      req_tdata;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready;
   logic [sstcp_pkg::RSP_DATA_W-1:0]      rsp_tdata;
   logic [sstcp_pkg::RSP_USER_W-1:0]      rsp_tuser;

   time_scoreboard sb;
   int             bytes_sent;
   int             cycle_count;
   bit             calm;

   serial_set_time_command_parser #(.LINE_MAX(LINE_MAX)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 30);
   end

   // handshake signals are stable between the falling and the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_verdict(rsp_tuser[0], rsp_tdata);
   end

   task automatic send_byte(input logic [7:0] b);
      bit took;
      calm = (bytes_sent >= 300 && bytes_sent < 450);
      while (!calm && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      sb.note_rx_byte(b, LINE_MAX);
      bytes_sent++;
   endtask

   task automatic send_line(input string s, input logic [7:0] term);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      send_byte(term);
   endtask

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == sstcp_pkg::CHAR_CR || b == sstcp_pkg::CHAR_LF);
      return b;
   endfunction

   task automatic send_random_line();
      logic [7:0] line [$];
      logic [7:0] ovf [$];
      string      cmd;
      int         kind;
      int         hh;
      int         mm;
      int         ss;
      int         n;
      if ($urandom_range(99) < 70) begin
         hh = $urandom_range(23);
         mm = $urandom_range(59);
         ss = $urandom_range(59);
      end else begin
         hh = $urandom_range(99);
         mm = $urandom_range(99);
         ss = $urandom_range(99);
      end
      cmd = $sformatf("SETTIME=%02d:%02d:%02d", hh, mm, ss);
      for (int i = 0; i < cmd.len(); i++) line.push_back(cmd[i]);
      kind = $urandom_range(99);
      if (kind < 55) begin
      end else if (kind < 65) begin
         line.push_back(sstcp_pkg::CHAR_NUL);
         n = $urandom_range(LINE_MAX - 2 - sstcp_pkg::CMD_LEN);
         repeat (n) line.push_back(body_byte());
      end else if (kind < 80) begin
         line[$urandom_range(line.size() - 1)] = body_byte();
      end else if (kind < 87) begin
         n = $urandom_range(1, sstcp_pkg::CMD_LEN - 1);
         while (line.size() > n) void'(line.pop_back());
      end else if (kind < 92) begin
         // full line plus extras; the first extra discards it
         repeat (LINE_MAX - 1 + $urandom_range(1, 3)) ovf.push_back(body_byte());
         line = {ovf, line};
      end else if (kind < 96) begin
         line.delete();
         n = $urandom_range(1, 30);
         repeat (n) line.push_back(8'($urandom_range(255)));
      end else begin
         line.delete();
      end
      line.push_back($urandom_range(1) ? sstcp_pkg::CHAR_CR : sstcp_pkg::CHAR_LF);
      if ($urandom_range(9) == 0) begin
         line.push_back($urandom_range(1) ? sstcp_pkg::CHAR_CR : sstcp_pkg::CHAR_LF);
      end
      foreach (line[i]) send_byte(line[i]);
   endtask

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      sb = new();
      bytes_sent = 0;
      calm = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_line("SETTIME=00:00:00", sstcp_pkg::CHAR_CR);
      send_line("SETTIME=23:59:59", sstcp_pkg::CHAR_LF);
      send_line("SETTIME=24:00:00", sstcp_pkg::CHAR_CR);
      send_line("SETTIME=19:60:00", sstcp_pkg::CHAR_CR);
      send_line("SETTIME=09:00:60", sstcp_pkg::CHAR_LF);
      send_line("SETTIME=12:34:5", sstcp_pkg::CHAR_CR);
      send_byte(sstcp_pkg::CHAR_CR);
      send_byte(sstcp_pkg::CHAR_LF);
      send_line("SETTIME=12:34:56X", sstcp_pkg::CHAR_CR);
      send_line("SETTIME=1/:34:56", sstcp_pkg::CHAR_CR);
      send_line("SETTIME=12:34:5:", sstcp_pkg::CHAR_LF);
      send_line("SETTIME=12;34:56", sstcp_pkg::CHAR_CR);
      send_line("setTIME=12:34:56", sstcp_pkg::CHAR_CR);
      send_line("SETTIME=", sstcp_pkg::CHAR_LF);
      // longest line: NUL at byte 16, tail fills to the limit
      send_line("SETTIME=12:34:56", sstcp_pkg::CHAR_NUL);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h01);
      send_byte(8'h0C);
      send_line("", 8'h0E);
      send_byte(sstcp_pkg::CHAR_CR);
      // overflow, then a good command on a fresh line
      repeat (LINE_MAX - 1) send_byte("A");
      send_byte("B");
      send_line("SETTIME=01:02:03", sstcp_pkg::CHAR_LF);

      while (bytes_sent < TOTAL_BYTES) send_random_line();
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d bytes: %0d lines accepted, %0d rejected,",
               bytes_sent, sb.n_accepted, sb.n_rejected);
      $display("including overflow, empty, short, padded and out-of-range lines.");
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

/* sim.f */
hdl/sstcp_pkg.sv
hdl/serial_set_time_command_parser.sv
bench/tb_serial_set_time_command_parser.sv
